FILE: hw/rtl/sva_pkg.sv
// Shared types and constants for the voice allocator.
// No dependencies.
package sva_pkg;

	// Size of the voice table; the voice fields are four bits wide.
	localparam int NUM_VOICES = 16;

	localparam logic [2:0] PH_FREE    = 3'd0;
	localparam logic [2:0] PH_ATTACK  = 3'd1;
	localparam logic [2:0] PH_DECAY   = 3'd2;
	localparam logic [2:0] PH_SUSTAIN = 3'd3;
	localparam logic [2:0] PH_RELEASE = 3'd4;
	localparam logic [2:0] PH_IDLE    = 3'd5;

	localparam logic [1:0] REQ_ON   = 2'd0;
	localparam logic [1:0] REQ_OFF  = 2'd1;
	localparam logic [1:0] REQ_REP  = 2'd2;
	localparam logic [1:0] REQ_STOP = 2'd3;

	localparam logic [2:0] ACT_NONE    = 3'd0;
	localparam logic [2:0] ACT_FREE    = 3'd1;
	localparam logic [2:0] ACT_IDLE    = 3'd2;
	localparam logic [2:0] ACT_STEAL   = 3'd3;
	localparam logic [2:0] ACT_LEGATO  = 3'd4;
	localparam logic [2:0] ACT_MONO    = 3'd5;
	localparam logic [2:0] ACT_RELEASE = 3'd6;
	localparam logic [2:0] ACT_ACK     = 3'd7;

	localparam logic [1:0] VM_MONO   = 2'd1;
	localparam logic [1:0] VM_LEGATO = 2'd2;
	localparam logic [1:0] AM_RR     = 2'd0;
	localparam logic [1:0] AM_RAND   = 2'd2;

	localparam logic [1:0] REG_VOICE_MODE = 2'd0;
	localparam logic [1:0] REG_ALLOC_MODE = 2'd1;
	localparam logic [1:0] REG_GLIDE      = 2'd2;

	localparam logic [15:0] LFSR_MASK = 16'hB400;

	// One request word as held in the queue.
	typedef struct packed {
		logic [1:0] req_type;
		logic [6:0] key;
		logic [3:0] channel;
		logic [3:0] voice_index;
		logic [2:0] new_phase;
	} req_t;

	function automatic logic [15:0] lfsr_step(input logic [15:0] l);
		lfsr_step = l[0] ? ((l >> 1) ^ LFSR_MASK) : (l >> 1);
	endfunction

endpackage

FILE: hw/rtl/sva_front.sv
// Front end: accepts request words and holds them in a two-entry queue.
// Depends on sva_pkg.
module sva_front import sva_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t in_req,
	output logic q_valid,
	output req_t q_req,
	input  logic q_pop
);

	req_t       slot_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;

	assign busy    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_req   = slot_q[rd_q];

	// Queue storage and pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (start && !busy) begin
				slot_q[wr_q] <= in_req;
				wr_q <= ~wr_q;
			end
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, start && !busy} - {1'b0, q_pop};
		end
	end

endmodule

FILE: hw/rtl/sva_back.sv
// Back end: scans the voice table one voice per cycle and applies each request.
// Depends on sva_pkg.
module sva_back import sva_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  req_t       q_req,
	output logic       q_pop,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [1:0] cfg_data,
	output logic       done,
	output logic [2:0] action,
	output logic [3:0] voice,
	output logic       glide,
	output logic [6:0] evicted_key,
	output logic [31:0] note_age
);

	localparam int VW = $clog2(NUM_VOICES);

	typedef enum logic [2:0] {S_IDLE, S_FREE, S_RAND, S_SCAN, S_APPLY} state_t;

	state_t      state_q;
	logic [2:0]  phase_q [NUM_VOICES];
	logic [31:0] age_q   [NUM_VOICES];
	logic [6:0]  key_q   [NUM_VOICES];
	logic [3:0]  chan_q  [NUM_VOICES];
	logic [NUM_VOICES-1:0] hold_q;
	logic [1:0]  vmode_q, amode_q;
	logic        glide_en_q;
	logic [VW-1:0] rr_q;
	logic [31:0] agec_q;
	logic [7:0]  held_q;
	logic [15:0] lfsr_q;
	req_t        req_q;
	logic [VW:0] cnt_q;
	logic [VW-1:0] pos_q;
	logic        fnd_free_q, fnd_idle_q, fnd_steal_q, fnd_off_q;
	logic [VW-1:0] free_v_q, idle_v_q, steal_v_q, off_v_q;
	logic [2:0]  steal_p_q;

	logic [15:0] lfsr_n;
	logic [VW-1:0] rand_v;
	logic [2:0]  cur_ph, cur_p;
	logic        mono;

	// The voice count is a power of two, so the probe is the low bits of the LFSR.
	assign lfsr_n = lfsr_step(lfsr_q);
	assign rand_v = lfsr_n[VW-1:0];
	assign cur_ph = phase_q[pos_q];
	assign mono   = (vmode_q == VM_MONO) || (vmode_q == VM_LEGATO);
	assign q_pop  = (state_q == S_IDLE) && q_valid;

	// Steal rank of the voice under scan.
	always_comb begin
		case (cur_ph)
			PH_SUSTAIN: cur_p = 3'd4;
			PH_RELEASE: cur_p = 3'd3;
			PH_DECAY:   cur_p = 3'd2;
			PH_ATTACK:  cur_p = 3'd1;
			default:    cur_p = 3'd0;
		endcase
	end

	// Sequencer: takes a word, scans the table, then applies the result.
	always_ff @(posedge clk or negedge arst_n) begin
		logic [VW-1:0] v;
		logic [2:0]    act;
		logic [6:0]    ek;
		if (!arst_n) begin
			state_q    <= S_IDLE;
			for (int i = 0; i < NUM_VOICES; i++) begin
				phase_q[i] <= PH_FREE;
				age_q[i]   <= '0;
			end
			hold_q     <= '0;
			vmode_q    <= '0;
			amode_q    <= '0;
			glide_en_q <= 1'b0;
			rr_q       <= '0;
			agec_q     <= '0;
			held_q     <= '0;
			lfsr_q     <= 16'd1;
			done       <= 1'b0;
			action     <= ACT_NONE;
			voice      <= '0;
			glide      <= 1'b0;
			evicted_key <= '0;
			note_age   <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_VOICE_MODE: begin vmode_q <= cfg_data; held_q <= '0; end
					REG_ALLOC_MODE: amode_q <= cfg_data;
					REG_GLIDE:      glide_en_q <= cfg_data[0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						req_q       <= q_req;
						cnt_q       <= '0;
						fnd_free_q  <= 1'b0;
						fnd_idle_q  <= 1'b0;
						fnd_steal_q <= 1'b0;
						fnd_off_q   <= 1'b0;
						steal_p_q   <= '0;
						if (q_req.req_type == REQ_ON && !mono) begin
							if (amode_q == AM_RAND) begin
								state_q <= S_RAND;
							end else begin
								pos_q   <= (amode_q == AM_RR) ? rr_q : '0;
								state_q <= S_FREE;
							end
						end else if (q_req.req_type == REQ_OFF && !mono) begin
							pos_q   <= '0;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_APPLY;
						end
					end
				end
				S_FREE: begin
					if (cur_ph == PH_FREE) begin
						fnd_free_q <= 1'b1;
						free_v_q   <= pos_q;
						pos_q      <= '0;
						state_q    <= S_APPLY;
					end else if (cnt_q == (VW+1)'(NUM_VOICES - 1)) begin
						pos_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_SCAN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						pos_q <= (pos_q == VW'(NUM_VOICES - 1)) ? '0 : pos_q + 1'b1;
					end
				end
				S_RAND: begin
					lfsr_q <= lfsr_n;
					if (phase_q[rand_v] == PH_FREE) begin
						fnd_free_q <= 1'b1;
						free_v_q   <= rand_v;
						state_q    <= S_APPLY;
					end else if (cnt_q == (VW+1)'(NUM_VOICES - 1)) begin
						pos_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_SCAN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SCAN: begin
					// Idle / steal search for note on, match search for note off.
					if (req_q.req_type == REQ_OFF) begin
						if (!fnd_off_q && hold_q[pos_q] && key_q[pos_q] == req_q.key
							&& chan_q[pos_q] == req_q.channel) begin
							fnd_off_q <= 1'b1;
							off_v_q   <= pos_q;
						end
					end else begin
						if (cur_ph == PH_IDLE &&
							(!fnd_idle_q || age_q[pos_q] < age_q[idle_v_q])) begin
							fnd_idle_q <= 1'b1;
							idle_v_q   <= pos_q;
						end
						if (cur_p != 3'd0 && (!fnd_steal_q || cur_p > steal_p_q ||
							(cur_p == steal_p_q && age_q[pos_q] < age_q[steal_v_q]))) begin
							fnd_steal_q <= 1'b1;
							steal_v_q   <= pos_q;
							steal_p_q   <= cur_p;
						end
					end
					if (cnt_q == (VW+1)'(NUM_VOICES - 1)) begin
						state_q <= S_APPLY;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						pos_q <= pos_q + 1'b1;
					end
				end
				S_APPLY: begin
					state_q     <= S_IDLE;
					done        <= 1'b1;
					action      <= ACT_NONE;
					voice       <= '0;
					glide       <= 1'b0;
					evicted_key <= '0;
					note_age    <= '0;
					case (req_q.req_type)
						REQ_ON: begin
							v   = '0;
							act = ACT_NONE;
							ek  = '0;
							if (mono) begin
								if (phase_q[0] == PH_FREE) act = ACT_FREE;
								else if (phase_q[0] == PH_IDLE) act = ACT_IDLE;
								else begin
									ek  = key_q[0];
									act = (vmode_q == VM_LEGATO) ? ACT_LEGATO : ACT_MONO;
								end
								if (held_q != 8'hFF) held_q <= held_q + 1'b1;
							end else if (fnd_free_q) begin
								v = free_v_q; act = ACT_FREE;
								if (amode_q == AM_RR || amode_q == AM_RAND)
									rr_q <= (free_v_q == VW'(NUM_VOICES - 1)) ? '0
										: free_v_q + 1'b1;
							end else if (fnd_idle_q) begin
								v = idle_v_q; act = ACT_IDLE;
							end else if (fnd_steal_q) begin
								v = steal_v_q; act = ACT_STEAL; ek = key_q[steal_v_q];
							end
							if (act != ACT_NONE) begin
								action      <= act;
								voice       <= 4'(v);
								glide       <= (phase_q[v] != PH_FREE) ? glide_en_q : 1'b0;
								evicted_key <= ek;
								note_age    <= agec_q;
								agec_q      <= agec_q + 1'b1;
								age_q[v]    <= agec_q;
								key_q[v]    <= req_q.key;
								chan_q[v]   <= req_q.channel;
								hold_q[v]   <= 1'b1;
								if (act != ACT_LEGATO) phase_q[v] <= PH_ATTACK;
							end
						end
						REQ_OFF: begin
							if (mono) begin
								if (held_q <= 8'd1) begin
									held_q <= '0;
									if (phase_q[0] >= PH_ATTACK && phase_q[0] <= PH_SUSTAIN) begin
										phase_q[0] <= PH_RELEASE;
										action     <= ACT_RELEASE;
									end
								end else begin
									held_q <= held_q - 1'b1;
								end
							end else if (fnd_off_q && phase_q[off_v_q] >= PH_ATTACK
								&& phase_q[off_v_q] <= PH_SUSTAIN) begin
								phase_q[off_v_q] <= PH_RELEASE;
								action <= ACT_RELEASE;
								voice  <= 4'(off_v_q);
							end
						end
						REQ_REP: begin
							if ({1'b0, req_q.voice_index} < 5'(NUM_VOICES)
								&& phase_q[VW'(req_q.voice_index)] != PH_FREE
								&& (req_q.new_phase == PH_DECAY
								|| req_q.new_phase == PH_SUSTAIN
								|| req_q.new_phase == PH_IDLE)) begin
								phase_q[VW'(req_q.voice_index)] <= req_q.new_phase;
								if (req_q.new_phase == PH_IDLE)
									hold_q[VW'(req_q.voice_index)] <= 1'b0;
								action <= ACT_ACK;
								voice  <= req_q.voice_index;
							end
						end
						default: begin
							if ({1'b0, req_q.voice_index} < 5'(NUM_VOICES)) begin
								phase_q[VW'(req_q.voice_index)] <= PH_FREE;
								hold_q[VW'(req_q.voice_index)]  <= 1'b0;
								action <= ACT_ACK;
								voice  <= req_q.voice_index;
							end
						end
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/synth_voice_allocator_unit.sv
// Top level of the voice allocator: front queue plus table sequencer.
// Depends on sva_pkg, sva_front and sva_back.
//
// A request word is taken when start is high and busy is low; up to two words
// queue while the back end works. Each word yields one result, shown on the
// result ports for one cycle with done high; the receiver cannot stall. Phase
// reports, hard stops and mono or legato words go straight to the apply step.
// A poly note-off first runs a match scan of the table. A poly note-on runs
// the free search, one voice or one random probe per cycle, then, if no free
// voice is found, an idle and steal scan of the table, one voice per cycle.
module synth_voice_allocator_unit import sva_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [6:0]  key,
	input  logic [3:0]  channel,
	input  logic [3:0]  voice_index,
	input  logic [2:0]  new_phase,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data,
	output logic        done,
	output logic [2:0]  action,
	output logic [3:0]  voice,
	output logic        glide,
	output logic [6:0]  evicted_key,
	output logic [31:0] note_age
);

	req_t in_req, q_req;
	logic q_valid, q_pop;

	assign in_req = '{req_type: req_type, key: key, channel: channel,
		voice_index: voice_index, new_phase: new_phase};

	// Request queue.
	sva_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_req(in_req),
		.q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
	);

	// Table sequencer.
	sva_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
		.action(action), .voice(voice), .glide(glide), .evicted_key(evicted_key),
		.note_age(note_age)
	);

endmodule
